[sv/seven_segment_two_wire_display_driver_defines.svh]
// Assertion helpers used by the top-level driver module.
`ifndef SEVEN_SEGMENT_TWO_WIRE_DISPLAY_DRIVER_DEFINES_SVH
`define SEVEN_SEGMENT_TWO_WIRE_DISPLAY_DRIVER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ssd: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ssd: next-cycle check failed");

`endif

[sv/ssd_pkg.sv]
`default_nettype none

package ssd_pkg;

    // Defaults for the top-level parameters.
    localparam int POSITION_COUNT_DEF = 4;
    localparam int BRIGHTNESS_TOP_DEF = 7;

    // Request codes.
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_RAW   = 3'd1;
    localparam logic [2:0] OP_DIGIT = 3'd2;
    localparam logic [2:0] OP_COLON = 3'd3;
    localparam logic [2:0] OP_DISP  = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DATA_CMD = 2'd0;
    localparam logic [1:0] CFG_ADDR_CMD = 2'd1;
    localparam logic [1:0] CFG_DISP_CMD = 2'd2;

    // Configuration reset values.
    localparam logic [7:0] DATA_CMD_RST = 8'h44;
    localparam logic [7:0] ADDR_CMD_RST = 8'hC0;
    localparam logic [7:0] DISP_CMD_RST = 8'h80;

    // The digit position that carries the colon in segment bit 7.
    localparam logic [1:0] COLON_POS    = 2'd1;
    localparam logic [7:0] COLON_BIT    = 8'h80;
    localparam logic [7:0] ALL_SEGS     = 8'hFF;
    localparam logic [7:0] BLANK_SEGS   = 8'h00;

    // Byte counts: raw, digit and colon requests queue three, display control one.
    localparam logic [1:0] CNT_DIGIT    = 2'd3;
    localparam logic [1:0] CNT_SINGLE   = 2'd1;
    localparam logic [1:0] CNT_SPLIT    = 2'd2;

    // Waveform phases, one-hot.
    typedef enum logic [8:0] {
        PH_IDLE     = 9'b000000001,
        PH_START_HI = 9'b000000010,
        PH_START_LO = 9'b000000100,
        PH_BIT_LO   = 9'b000001000,
        PH_BIT_HI   = 9'b000010000,
        PH_ACK_LO   = 9'b000100000,
        PH_ACK_HI   = 9'b001000000,
        PH_STOP_LO  = 9'b010000000,
        PH_STOP_HI  = 9'b100000000
    } t_phase;

    // Bytes handed from the request builder to the sequencer.
    typedef struct packed {
        logic            valid;
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
    } t_load;

    // Pin levels and status from the sequencer.
    typedef struct packed {
        logic clk_level;
        logic dio_level;
        logic dio_driven;
        logic busy;
        logic no_ack;
        logic idle;
    } t_wave;

    // Segment pattern of a decimal digit; 10 and above blank the digit.
    function automatic logic [7:0] seg_code(input logic [7:0] digit);
        logic [7:0] segs;
        case (digit)
            8'd0: segs = 8'h3F;
            8'd1: segs = 8'h06;
            8'd2: segs = 8'h5B;
            8'd3: segs = 8'h4F;
            8'd4: segs = 8'h66;
            8'd5: segs = 8'h6D;
            8'd6: segs = 8'h7D;
            8'd7: segs = 8'h07;
            8'd8: segs = 8'h7F;
            8'd9: segs = 8'h6F;
            default: segs = BLANK_SEGS;
        endcase
        return segs;
    endfunction

endpackage

`default_nettype wire

[sv/ssd_in_if.sv]
`default_nettype none

interface ssd_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [1:0] position;
    logic [7:0] value;
    logic       enable;
    logic       dio_in;

    modport source (
        output valid, opcode, position, value, enable, dio_in,
        input  ready
    );
    modport sink (
        input  valid, opcode, position, value, enable, dio_in,
        output ready
    );
endinterface

`default_nettype wire

[sv/ssd_out_if.sv]
`default_nettype none

interface ssd_out_if;
    logic valid;
    logic ready;
    logic clk_level;
    logic dio_level;
    logic dio_driven;
    logic busy_res;
    logic accepted;
    logic no_ack;

    modport source (
        output valid, clk_level, dio_level, dio_driven, busy_res, accepted, no_ack,
        input  ready
    );
    modport sink (
        input  valid, clk_level, dio_level, dio_driven, busy_res, accepted, no_ack,
        output ready
    );
endinterface

`default_nettype wire

[sv/seven_segment_two_wire_display_driver.sv]
// Two-wire serial master for a four-digit seven-segment display driver chip.
// Beats arrive on i_req: a tick (opcode tick) plays one delay period of the
// bit-banged waveform, and a request opcode (raw segments, decimal digit,
// colon, display control) is taken only while the line is idle; the other
// codes are neither. Every input beat gives exactly one result beat on o_res,
// holding the clock and data pin levels for that period, whether the data line
// is driven or released for the ack slot, the busy flag, whether the request
// was taken, and the level last sampled in an ack slot.
// The result of a beat is registered and shows in the cycle after it is
// accepted. Throughput is one beat per cycle while the receiver takes results;
// the work per beat is a single pass through the request builder and the phase
// sequencer into the result register. While a result waits in that register
// the block still accepts a beat at the same edge at which the result is
// taken; if the receiver stalls, i_req.ready falls and the waiting result holds.
// The user writes the three command bytes on i_cfg only while idle; the block
// does not enforce it. Reset (synchronous, active low) leaves the line idle
// with no transfer queued, the command bytes at their defaults, the colon
// digit all lit and the display on at full brightness.
`default_nettype none

`include "seven_segment_two_wire_display_driver_defines.svh"

module seven_segment_two_wire_display_driver #(
    parameter int POSITION_COUNT = ssd_pkg::POSITION_COUNT_DEF,
    parameter int BRIGHTNESS_TOP = ssd_pkg::BRIGHTNESS_TOP_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    ssd_in_if.sink          i_req,
    ssd_out_if.source       o_res,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    // Command byte registers, to be written only while the block is idle; the block does not enforce it.
    logic [7:0] r_data_cmd;
    logic [7:0] r_addr_cmd;
    logic [7:0] r_disp_cmd;

    // Result register: one beat waiting for the receiver.
    logic r_out_valid;
    logic r_clk_level;
    logic r_dio_level;
    logic r_dio_driven;
    logic r_busy;
    logic r_accepted;
    logic r_no_ack;

    logic           in_beat;
    logic           is_tick;
    logic           is_request;
    logic           take;
    ssd_pkg::t_load load;
    ssd_pkg::t_wave wave;

    // The input side is open whenever the result register is empty or its
    // beat is being taken in this cycle.
    assign i_req.ready = !r_out_valid || o_res.ready;
    assign in_beat     = i_req.valid && i_req.ready;
    assign is_tick     = (i_req.opcode == ssd_pkg::OP_TICK);
    assign is_request  = i_req.opcode inside {ssd_pkg::OP_RAW, ssd_pkg::OP_DIGIT,
                                              ssd_pkg::OP_COLON, ssd_pkg::OP_DISP};
    // A request is taken only with the line idle; otherwise it is dropped
    // and reported with accepted low.
    assign take        = in_beat && is_request && wave.idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_cmd <= ssd_pkg::DATA_CMD_RST;
            r_addr_cmd <= ssd_pkg::ADDR_CMD_RST;
            r_disp_cmd <= ssd_pkg::DISP_CMD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ssd_pkg::CFG_DATA_CMD: r_data_cmd <= i_cfg_data;
                ssd_pkg::CFG_ADDR_CMD: r_addr_cmd <= i_cfg_data;
                ssd_pkg::CFG_DISP_CMD: r_disp_cmd <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ssd_req #(
        .POSITION_COUNT (POSITION_COUNT),
        .BRIGHTNESS_TOP (BRIGHTNESS_TOP)
    ) u_req (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_opcode   (i_req.opcode),
        .i_position (i_req.position),
        .i_value    (i_req.value),
        .i_enable   (i_req.enable),
        .i_data_cmd (r_data_cmd),
        .i_addr_cmd (r_addr_cmd),
        .i_disp_cmd (r_disp_cmd),
        .o_load     (load)
    );

    ssd_wave u_wave (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (in_beat && is_tick),
        .i_dio_in (i_req.dio_in),
        .i_load   (load),
        .o_wave   (wave)
    );

    // The pin levels reflect the phase before this beat; busy and the ack
    // flag reflect the state the beat leaves behind.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_beat) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_clk_level  <= wave.clk_level;
            r_dio_level  <= wave.dio_level;
            r_dio_driven <= wave.dio_driven;
            r_busy       <= wave.busy;
            r_accepted   <= take;
            r_no_ack     <= wave.no_ack;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.clk_level  = r_clk_level;
    assign o_res.dio_level  = r_dio_level;
    assign o_res.dio_driven = r_dio_driven;
    assign o_res.busy_res   = r_busy;
    assign o_res.accepted   = r_accepted;
    assign o_res.no_ack     = r_no_ack;

    // A taken request always starts a transfer.
    `SSD_ASSERT_NOW(a_taken_is_busy, i_clk, i_rst_n, r_out_valid && r_accepted, r_busy)
    // A taken request leaves the sequencer out of idle in the next cycle.
    `SSD_ASSERT_NEXT(a_take_leaves_idle, i_clk, i_rst_n, take, !wave.idle)
    // A released data line is never reported with a high drive level.
    `SSD_ASSERT_NOW(a_release_low, i_clk, i_rst_n, r_out_valid && !r_dio_driven,
                    !r_dio_level)

endmodule

`default_nettype wire

[sv/ssd_req.sv]
`default_nettype none

// Turns a request into the bytes of its frames and keeps the colon digit
// and the display control setting.
module ssd_req #(
    parameter int POSITION_COUNT = ssd_pkg::POSITION_COUNT_DEF,
    parameter int BRIGHTNESS_TOP = ssd_pkg::BRIGHTNESS_TOP_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_take,
    input  wire logic [2:0]     i_opcode,
    input  wire logic [1:0]     i_position,
    input  wire logic [7:0]     i_value,
    input  wire logic           i_enable,
    input  wire logic [7:0]     i_data_cmd,
    input  wire logic [7:0]     i_addr_cmd,
    input  wire logic [7:0]     i_disp_cmd,
    output ssd_pkg::t_load      o_load
);

    localparam logic [7:0] PosMask   = 8'(POSITION_COUNT - 1);
    localparam logic [7:0] BrightMax = 8'(BRIGHTNESS_TOP);
    localparam logic [3:0] DispRst   = {1'b1, 3'(BRIGHTNESS_TOP)};

    logic [7:0] r_colon;
    logic [7:0] n_colon;
    logic [3:0] r_disp;
    logic [3:0] n_disp;
    logic [7:0] segs;
    logic [2:0] bright;

    always_comb begin
        n_colon       = r_colon;
        n_disp        = r_disp;
        segs          = ssd_pkg::seg_code(i_value);
        bright        = (i_value > BrightMax) ? BrightMax[2:0] : i_value[2:0];
        o_load.valid  = i_take;
        o_load.count  = ssd_pkg::CNT_DIGIT;
        o_load.bytes[0] = i_data_cmd;
        o_load.bytes[1] = i_addr_cmd | ({6'b0, i_position} & PosMask);
        o_load.bytes[2] = i_value;
        case (i_opcode)
            ssd_pkg::OP_DIGIT: begin
                if (i_position == ssd_pkg::COLON_POS) begin
                    segs    = segs | (r_colon & ssd_pkg::COLON_BIT);
                    n_colon = segs;
                end
                o_load.bytes[2] = segs;
            end
            ssd_pkg::OP_COLON: begin
                n_colon         = {(i_value != 8'd0), r_colon[6:0]};
                o_load.bytes[1] = i_addr_cmd | ({6'b0, ssd_pkg::COLON_POS} & PosMask);
                o_load.bytes[2] = n_colon;
            end
            ssd_pkg::OP_DISP: begin
                n_disp          = {i_enable, bright};
                o_load.count    = ssd_pkg::CNT_SINGLE;
                o_load.bytes[0] = i_disp_cmd | {4'b0, n_disp};
                o_load.bytes[1] = 8'd0;
                o_load.bytes[2] = 8'd0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colon <= ssd_pkg::ALL_SEGS;
            r_disp  <= DispRst;
        end else if (i_take) begin
            r_colon <= n_colon;
            r_disp  <= n_disp;
        end
    end

endmodule

`default_nettype wire

[sv/ssd_wave.sv]
`default_nettype none

// Waveform sequencer: one phase of the two-wire waveform per tick.
module ssd_wave (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_step,
    input  wire logic           i_dio_in,
    input  wire ssd_pkg::t_load i_load,
    output ssd_pkg::t_wave      o_wave
);

    ssd_pkg::t_phase  r_phase, n_phase;
    logic [2:0]       r_bit_idx, n_bit_idx;
    logic [7:0]       r_shift, n_shift;
    logic [2:0][7:0]  r_pend, n_pend;
    logic [1:0]       r_cnt, n_cnt;
    logic             r_split, n_split;
    logic             r_ack, n_ack;
    logic             load_next;

    always_comb begin
        o_wave.clk_level  = 1'b1;
        o_wave.dio_level  = 1'b1;
        o_wave.dio_driven = 1'b1;
        case (r_phase)
            ssd_pkg::PH_START_LO: o_wave.dio_level = 1'b0;
            ssd_pkg::PH_BIT_LO: begin
                o_wave.clk_level = 1'b0;
                o_wave.dio_level = r_shift[0];
            end
            ssd_pkg::PH_BIT_HI: o_wave.dio_level = r_shift[0];
            ssd_pkg::PH_ACK_LO: begin
                o_wave.clk_level  = 1'b0;
                o_wave.dio_level  = 1'b0;
                o_wave.dio_driven = 1'b0;
            end
            ssd_pkg::PH_ACK_HI: begin
                o_wave.dio_level  = 1'b0;
                o_wave.dio_driven = 1'b0;
            end
            ssd_pkg::PH_STOP_LO: begin
                o_wave.clk_level = 1'b0;
                o_wave.dio_level = 1'b0;
            end
            ssd_pkg::PH_STOP_HI: o_wave.dio_level = 1'b0;
            default: begin
            end
        endcase

        n_phase   = r_phase;
        n_bit_idx = r_bit_idx;
        n_shift   = r_shift;
        n_pend    = r_pend;
        n_cnt     = r_cnt;
        n_split   = r_split;
        n_ack     = r_ack;
        load_next = 1'b0;
        if (i_step) begin
            case (r_phase)
                ssd_pkg::PH_START_HI: n_phase = ssd_pkg::PH_START_LO;
                ssd_pkg::PH_START_LO: begin
                    n_split   = (r_cnt == ssd_pkg::CNT_SPLIT);
                    load_next = 1'b1;
                    n_phase   = ssd_pkg::PH_BIT_LO;
                end
                ssd_pkg::PH_BIT_LO: n_phase = ssd_pkg::PH_BIT_HI;
                ssd_pkg::PH_BIT_HI: begin
                    if (&r_bit_idx) begin
                        n_phase = ssd_pkg::PH_ACK_LO;
                    end else begin
                        n_bit_idx = r_bit_idx + 3'd1;
                        n_shift   = {1'b0, r_shift[7:1]};
                        n_phase   = ssd_pkg::PH_BIT_LO;
                    end
                end
                ssd_pkg::PH_ACK_LO: n_phase = ssd_pkg::PH_ACK_HI;
                ssd_pkg::PH_ACK_HI: begin
                    n_ack = i_dio_in;
                    if (r_split) begin
                        n_split   = 1'b0;
                        load_next = 1'b1;
                        n_phase   = ssd_pkg::PH_BIT_LO;
                    end else begin
                        n_phase = ssd_pkg::PH_STOP_LO;
                    end
                end
                ssd_pkg::PH_STOP_LO: n_phase = ssd_pkg::PH_STOP_HI;
                ssd_pkg::PH_STOP_HI: begin
                    n_phase = (r_cnt != 2'd0) ? ssd_pkg::PH_START_HI : ssd_pkg::PH_IDLE;
                end
                default: n_phase = ssd_pkg::PH_IDLE;
            endcase
            if (load_next) begin
                n_shift   = r_pend[0];
                n_pend[0] = r_pend[1];
                n_pend[1] = r_pend[2];
                n_pend[2] = 8'd0;
                n_cnt     = (r_cnt != 2'd0) ? r_cnt - 2'd1 : r_cnt;
                n_bit_idx = 3'd0;
            end
        end else if (i_load.valid) begin
            n_pend  = i_load.bytes;
            n_cnt   = i_load.count;
            n_split = 1'b0;
            n_phase = ssd_pkg::PH_START_HI;
        end
        o_wave.busy   = (n_phase != ssd_pkg::PH_IDLE);
        o_wave.no_ack = n_ack;
        o_wave.idle   = (r_phase == ssd_pkg::PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= ssd_pkg::PH_IDLE;
            r_bit_idx <= 3'd0;
            r_shift   <= 8'd0;
            r_cnt     <= 2'd0;
            r_split   <= 1'b0;
            r_ack     <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_bit_idx <= n_bit_idx;
            r_shift   <= n_shift;
            r_cnt     <= n_cnt;
            r_split   <= n_split;
            r_ack     <= n_ack;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

endmodule

`default_nettype wire
